### rtl/sorted_list_engine_core_defines.svh
// Assertion macros for the sorted list engine core
`ifndef SORTED_LIST_ENGINE_CORE_DEFINES_SVH
`define SORTED_LIST_ENGINE_CORE_DEFINES_SVH

`ifndef SYNTH
`define SLE_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define SLE_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SLE_ASSERT(lbl, clk, rst_n, prop, msg)
`define SLE_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

### rtl/sle_pkg.sv
// Shared constants, codes and types of the sorted list engine
package sle_pkg;

  localparam int CAPACITY = 16;
  localparam int DATA_W   = 32;
  localparam int COUNT_W  = 5;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  typedef enum logic [1:0] {
    REQ_INSERT   = 2'd0,
    REQ_DELETE   = 2'd1,
    REQ_READ_ALL = 2'd2,
    REQ_CLEAR    = 2'd3
  } req_type_e;

  typedef enum logic [1:0] {
    STAT_DONE      = 2'd0,
    STAT_FULL      = 2'd1,
    STAT_NOT_FOUND = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INS_WALK,
    ST_INS_PUT,
    ST_DEL_FIND,
    ST_DEL_SHIFT,
    ST_RD_OUT,
    ST_RESP
  } state_e;

  typedef struct packed {
    logic              we;
    logic [IDX_W-1:0]  waddr;
    logic [DATA_W-1:0] wdata;
    logic              re;
    logic [IDX_W-1:0]  raddr;
  } mem_req_t;

endpackage

### rtl/sle_req_if.sv
// Request channel: command and value
interface sle_req_if;
  logic                              valid;
  logic                              ready;
  logic [1:0]                        req_type;
  logic signed [sle_pkg::DATA_W-1:0] value;

  modport source (output valid, output req_type, output value, input ready);
  modport sink   (input valid, input req_type, input value, output ready);
endinterface

### rtl/sle_rsp_if.sv
// Response channel: status, element, count and last flag
interface sle_rsp_if;
  logic                              valid;
  logic                              ready;
  logic [1:0]                        status;
  logic signed [sle_pkg::DATA_W-1:0] element;
  logic                              element_valid;
  logic [sle_pkg::COUNT_W-1:0]       count;
  logic                              last;

  modport source (output valid, output status, output element, output element_valid,
                  output count, output last, input ready);
  modport sink   (input valid, input status, input element, input element_valid,
                  input count, input last, output ready);
endinterface

### rtl/sle_store.sv
// Value store: one write port, one read port with registered read data
module sle_store (
  input  logic                        clk_i,
  input  sle_pkg::mem_req_t           mem_i,
  output logic [sle_pkg::DATA_W-1:0]  rd_data_o
);
  import sle_pkg::*;

  logic [DATA_W-1:0] mem [CAPACITY];
  logic [DATA_W-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (mem_i.we) begin
      mem[mem_i.waddr] <= mem_i.wdata;
    end
    if (mem_i.re) begin
      rd_data_q <= mem[mem_i.raddr];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

### rtl/sorted_list_engine_core.sv
// Sorted list engine: keeps up to CAPACITY signed values in ascending order.
// Requests insert, delete, read out or clear; one request is worked at a time and the
// request channel is ready only while the sequencer is idle. A store with one write and one
// read port is walked one entry per cycle through its registered read port, but a read out
// holds its walk while the response register is still full. The response register lets a new
// request start while the last result still waits to be taken.
`include "sorted_list_engine_core_defines.svh"

module sorted_list_engine_core (
  input  logic clk_i,
  input  logic rst_ni,
  sle_req_if.sink   req_i,
  sle_rsp_if.source rsp_o
);
  import sle_pkg::*;

  state_e                    state_q, state_d;
  logic [CNT_W-1:0]          cnt_q, cnt_d;
  logic [CNT_W-1:0]          ptr_q, ptr_d;
  logic signed [DATA_W-1:0]  val_q, val_d;
  status_e                   status_q, status_d;

  mem_req_t                  mem_req;
  logic signed [DATA_W-1:0]  rd_data;

  logic                      rsp_valid_q;
  status_e                   rsp_status_q;
  logic signed [DATA_W-1:0]  rsp_elem_q;
  logic                      rsp_evalid_q;
  logic [CNT_W-1:0]          rsp_cnt_q;
  logic                      rsp_last_q;

  logic                      out_load;
  logic signed [DATA_W-1:0]  out_elem;
  logic                      out_evalid;
  logic                      out_last;

  logic                      slot_free;
  logic                      cmp_lt, cmp_eq;
  logic [CNT_W-1:0]          ptr_inc, ptr_dec, ptr_inc2, cnt_dec;
  logic                      rd_is_last;
  req_type_e                 req_kind;

  sle_store u_store (
    .clk_i     (clk_i),
    .mem_i     (mem_req),
    .rd_data_o (rd_data)
  );

  assign slot_free  = !rsp_valid_q || rsp_o.ready;
  assign cmp_lt     = rd_data < val_q;
  assign cmp_eq     = rd_data == val_q;
  assign ptr_inc    = ptr_q + 1'b1;
  assign ptr_inc2   = ptr_inc + 1'b1;
  assign ptr_dec    = ptr_q - 1'b1;
  assign cnt_dec    = cnt_q - 1'b1;
  assign rd_is_last = ptr_inc == cnt_q;
  assign req_kind   = req_type_e'(req_i.req_type);

  assign req_i.ready = state_q == ST_IDLE;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (req_i.valid) begin
          unique case (req_kind)
            REQ_INSERT: begin
              if (cnt_q == CNT_W'(CAPACITY) || cnt_q == '0) begin
                state_d = ST_RESP;
              end else begin
                state_d = ST_INS_WALK;
              end
            end
            REQ_DELETE:   state_d = (cnt_q == '0) ? ST_RESP : ST_DEL_FIND;
            REQ_READ_ALL: state_d = (cnt_q == '0) ? ST_RESP : ST_RD_OUT;
            REQ_CLEAR:    state_d = ST_RESP;
            default:      state_d = ST_RESP;
          endcase
        end
      end
      ST_INS_WALK: begin
        if (cmp_lt) begin
          state_d = ST_RESP;
        end else if (ptr_q == '0) begin
          state_d = ST_INS_PUT;
        end
      end
      ST_INS_PUT: state_d = ST_RESP;
      ST_DEL_FIND: begin
        if (cmp_eq) begin
          state_d = ST_DEL_SHIFT;
        end else if (rd_is_last) begin
          state_d = ST_RESP;
        end
      end
      ST_DEL_SHIFT: begin
        if (!(ptr_inc < cnt_q)) begin
          state_d = ST_RESP;
        end
      end
      ST_RD_OUT: begin
        if (slot_free && rd_is_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_RESP: begin
        if (slot_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    mem_req       = '0;
    mem_req.wdata = val_q;
    ptr_d         = ptr_q;
    cnt_d         = cnt_q;
    val_d         = val_q;
    status_d      = status_q;
    out_load      = 1'b0;
    out_elem      = '0;
    out_evalid    = 1'b0;
    out_last      = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        if (req_i.valid) begin
          val_d    = req_i.value;
          status_d = STAT_DONE;
          unique case (req_kind)
            REQ_INSERT: begin
              if (cnt_q == CNT_W'(CAPACITY)) begin
                status_d = STAT_FULL;
              end else if (cnt_q == '0) begin
                mem_req.we    = 1'b1;
                mem_req.waddr = '0;
                mem_req.wdata = req_i.value;
                cnt_d         = CNT_W'(1);
              end else begin
                mem_req.re    = 1'b1;
                mem_req.raddr = cnt_dec[IDX_W-1:0];
                ptr_d         = cnt_dec;
              end
            end
            REQ_DELETE: begin
              if (cnt_q == '0) begin
                status_d = STAT_NOT_FOUND;
              end else begin
                mem_req.re    = 1'b1;
                mem_req.raddr = '0;
                ptr_d         = '0;
              end
            end
            REQ_READ_ALL: begin
              mem_req.re    = 1'b1;
              mem_req.raddr = '0;
              ptr_d         = '0;
            end
            REQ_CLEAR: cnt_d = '0;
            default: ;
          endcase
        end
      end
      ST_INS_WALK: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = ptr_inc[IDX_W-1:0];
        if (cmp_lt) begin
          cnt_d = cnt_q + 1'b1;
        end else begin
          mem_req.wdata = rd_data;
          if (ptr_q != '0) begin
            mem_req.re    = 1'b1;
            mem_req.raddr = ptr_dec[IDX_W-1:0];
            ptr_d         = ptr_dec;
          end
        end
      end
      ST_INS_PUT: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = ptr_q[IDX_W-1:0];
        cnt_d         = cnt_q + 1'b1;
      end
      ST_DEL_FIND: begin
        if (cmp_eq) begin
          mem_req.re    = 1'b1;
          mem_req.raddr = ptr_inc[IDX_W-1:0];
        end else if (rd_is_last) begin
          status_d = STAT_NOT_FOUND;
        end else begin
          mem_req.re    = 1'b1;
          mem_req.raddr = ptr_inc[IDX_W-1:0];
          ptr_d         = ptr_inc;
        end
      end
      ST_DEL_SHIFT: begin
        if (ptr_inc < cnt_q) begin
          mem_req.we    = 1'b1;
          mem_req.waddr = ptr_q[IDX_W-1:0];
          mem_req.wdata = rd_data;
          mem_req.re    = 1'b1;
          mem_req.raddr = ptr_inc2[IDX_W-1:0];
          ptr_d         = ptr_inc;
        end else begin
          cnt_d = cnt_dec;
        end
      end
      ST_RD_OUT: begin
        if (slot_free) begin
          out_load   = 1'b1;
          out_elem   = rd_data;
          out_evalid = 1'b1;
          out_last   = rd_is_last;
          if (!rd_is_last) begin
            mem_req.re    = 1'b1;
            mem_req.raddr = ptr_inc[IDX_W-1:0];
            ptr_d         = ptr_inc;
          end
        end
      end
      ST_RESP: begin
        out_load = slot_free;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      if (out_load) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    ptr_q    <= ptr_d;
    val_q    <= val_d;
    status_q <= status_d;
    if (out_load) begin
      rsp_status_q <= status_q;
      rsp_elem_q   <= out_elem;
      rsp_evalid_q <= out_evalid;
      rsp_cnt_q    <= cnt_q;
      rsp_last_q   <= out_last;
    end
  end

  assign rsp_o.valid         = rsp_valid_q;
  assign rsp_o.status        = rsp_status_q;
  assign rsp_o.element       = rsp_elem_q;
  assign rsp_o.element_valid = rsp_evalid_q;
  assign rsp_o.count         = COUNT_W'(rsp_cnt_q);
  assign rsp_o.last          = rsp_last_q;

  `SLE_ASSERT_ALWAYS(a_cnt_bound, clk_i, !rst_ni || cnt_q <= CNT_W'(CAPACITY), "count exceeds capacity")
  `SLE_ASSERT(a_walk_ptr, clk_i, rst_ni, (state_q == ST_INS_WALK || state_q == ST_DEL_FIND || state_q == ST_RD_OUT) |-> ptr_q < cnt_q, "walk pointer beyond count")
  `SLE_ASSERT(a_load_free, clk_i, rst_ni, out_load |-> slot_free, "response overwritten before transfer")
  `SLE_ASSERT(a_mid_elem, clk_i, rst_ni, (rsp_valid_q && !rsp_last_q) |-> (rsp_evalid_q && rsp_status_q == STAT_DONE), "non-final response without element")

endmodule

### dv/tb_sorted_list_engine_core.sv
// Testbench for the sorted list engine core: mirrored list, random traffic and result checks
`timescale 1ns / 1ps

import sle_pkg::*;

typedef struct {
  logic [1:0]               status;
  logic signed [DATA_W-1:0] element;
  logic                     element_valid;
  logic [COUNT_W-1:0]       count;
  logic                     last;
} list_result_t;

class sorted_list_mirror;
  logic signed [DATA_W-1:0] entries [CAPACITY];
  int unsigned              fill = 0;
  int unsigned              mismatches = 0;
  list_result_t             owed_results [$];

  function void owe(status_e st, logic signed [DATA_W-1:0] elem, logic ev, logic lst);
    list_result_t r;
    r.status        = st;
    r.element       = elem;
    r.element_valid = ev;
    r.count         = fill[COUNT_W-1:0];
    r.last          = lst;
    owed_results.push_back(r);
  endfunction

  function logic signed [DATA_W-1:0] pick_stored();
    return entries[$urandom_range(0, fill - 1)];
  endfunction

  function void apply_request(req_type_e kind, logic signed [DATA_W-1:0] v);
    int unsigned pos;
    case (kind)
      REQ_INSERT: begin
        if (fill >= CAPACITY) begin
          owe(STAT_FULL, '0, 1'b0, 1'b1);
        end else begin
          pos = 0;
          while (pos < fill && entries[pos] < v) pos++;
          for (int unsigned i = fill; i > pos; i--) entries[i] = entries[i - 1];
          entries[pos] = v;
          fill++;
          owe(STAT_DONE, '0, 1'b0, 1'b1);
        end
      end
      REQ_DELETE: begin
        pos = 0;
        while (pos < fill && entries[pos] != v) pos++;
        if (pos >= fill) begin
          owe(STAT_NOT_FOUND, '0, 1'b0, 1'b1);
        end else begin
          for (int unsigned i = pos; i + 1 < fill; i++) entries[i] = entries[i + 1];
          fill--;
          owe(STAT_DONE, '0, 1'b0, 1'b1);
        end
      end
      REQ_READ_ALL: begin
        if (fill == 0) begin
          owe(STAT_DONE, '0, 1'b0, 1'b1);
        end else begin
          for (int unsigned i = 0; i < fill; i++) owe(STAT_DONE, entries[i], 1'b1, i + 1 == fill);
        end
      end
      default: begin
        fill = 0;
        owe(STAT_DONE, '0, 1'b0, 1'b1);
      end
    endcase
  endfunction

  function void check_result(list_result_t got);
    list_result_t want;
    if (owed_results.size() == 0) begin
      mismatches++;
      $display("%0t: unexpected result status=%0d element=%0d valid=%0b count=%0d last=%0b",
               $time, got.status, got.element, got.element_valid, got.count, got.last);
      return;
    end
    want = owed_results.pop_front();
    if (got.status !== want.status || got.element !== want.element ||
        got.element_valid !== want.element_valid || got.count !== want.count ||
        got.last !== want.last) begin
      mismatches++;
      $display("%0t: expected status=%0d element=%0d valid=%0b count=%0d last=%0b", $time,
               want.status, want.element, want.element_valid, want.count, want.last);
      $display("%0t: actual   status=%0d element=%0d valid=%0b count=%0d last=%0b", $time,
               got.status, got.element, got.element_valid, got.count, got.last);
    end
  endfunction
endclass

module tb_sorted_list_engine_core;
  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  sle_req_if req_if ();
  sle_rsp_if rsp_if ();

  sorted_list_engine_core dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  sorted_list_mirror mirror = new();
  int unsigned       transfers_in = 0;
  bit                calm_phase = 1'b0;
  bit                rsp_hold = 1'b0;

  always #2 clk_i = ~clk_i;

  function automatic int unsigned idle_len();
    int unsigned r;
    if (calm_phase) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic signed [DATA_W-1:0] pick_value();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 40) return $urandom_range(0, 16) - 8;
    if (r < 55) return 32'sh7fffffff - $urandom_range(0, 3);
    if (r < 70) return 32'sh80000000 + $urandom_range(0, 3);
    return $urandom();
  endfunction

  task automatic send_request(req_type_e kind, logic signed [DATA_W-1:0] v);
    int unsigned gap;
    req_if.valid    <= 1'b1;
    req_if.req_type <= kind;
    req_if.value    <= v;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    mirror.apply_request(kind, v);
    transfers_in++;
    gap = idle_len();
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      req_if.value <= $urandom();
      repeat (gap) @(posedge clk_i);
    end
  endtask

  initial begin
    req_type_e                kind;
    logic signed [DATA_W-1:0] v;
    int unsigned              ins_pct;
    int unsigned              r;
    req_if.valid    <= 1'b0;
    req_if.req_type <= REQ_INSERT;
    req_if.value    <= '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_request(REQ_READ_ALL, 32'sd0);
    send_request(REQ_DELETE, 32'sd7);
    send_request(REQ_CLEAR, -32'sd1);
    send_request(REQ_INSERT, 32'sh7fffffff);
    send_request(REQ_INSERT, 32'sh80000000);
    send_request(REQ_INSERT, 32'sd0);
    send_request(REQ_INSERT, -32'sd1);
    send_request(REQ_INSERT, 32'sd1);
    send_request(REQ_INSERT, 32'sd0);
    send_request(REQ_READ_ALL, 32'sh80000000);
    send_request(REQ_DELETE, 32'sh80000000);
    send_request(REQ_DELETE, 32'sd5);
    for (int k = 0; k < 11; k++) send_request(REQ_INSERT, pick_value());
    send_request(REQ_INSERT, 32'sd3);
    send_request(REQ_READ_ALL, 32'sh7fffffff);
    send_request(REQ_CLEAR, 32'sh7fffffff);
    send_request(REQ_READ_ALL, $urandom());

    ins_pct = 65;
    for (int k = 0; k < 400; k++) begin
      if (k % 50 == 0) ins_pct = $urandom_range(0, 1) ? 65 : 35;
      r = $urandom_range(0, 99);
      if (r < ins_pct) kind = REQ_INSERT;
      else if (r < 85) kind = REQ_DELETE;
      else if (r < 97) kind = REQ_READ_ALL;
      else kind = REQ_CLEAR;
      if (kind == REQ_DELETE && mirror.fill > 0 && $urandom_range(0, 2) != 0)
        v = mirror.pick_stored();
      else if (kind == REQ_INSERT || kind == REQ_DELETE)
        v = pick_value();
      else
        v = $urandom();
      send_request(kind, v);
    end
    req_if.valid <= 1'b0;

    while (mirror.owed_results.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (mirror.mismatches == 0 && mirror.owed_results.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    int unsigned  stall;
    list_result_t got;
    stall = 0;
    rsp_if.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (rsp_if.valid && rsp_if.ready) begin
        got.status        = rsp_if.status;
        got.element       = rsp_if.element;
        got.element_valid = rsp_if.element_valid;
        got.count         = rsp_if.count;
        got.last          = rsp_if.last;
        mirror.check_result(got);
      end
      if (stall > 0) stall--;
      else stall = idle_len();
      rsp_if.ready <= !rsp_hold && stall == 0;
    end
  end

  // hold off the response side long enough to back up the request channel
  initial begin
    wait (transfers_in >= 150);
    @(posedge clk_i);
    rsp_hold <= 1'b1;
    repeat (400) @(posedge clk_i);
    rsp_hold <= 1'b0;
  end

  always begin
    repeat ($urandom_range(150, 500)) @(posedge clk_i);
    calm_phase <= ($urandom_range(0, 3) == 0);
  end

  initial begin
    #6000000;
    $display("[FAIL] regression broken");
    $finish;
  end
endmodule

### sorted_list_engine_core.f
+incdir+rtl
rtl/sle_pkg.sv
rtl/sle_req_if.sv
rtl/sle_rsp_if.sv
rtl/sle_store.sv
rtl/sorted_list_engine_core.sv
dv/tb_sorted_list_engine_core.sv
